[sv/assert_macros.svh]
// assertion macros shared by the pixel writer modules
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_SAME(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[sv/fpw_pkg.sv]
// shared types, codes and the channel scaling function of the pixel writer
// no dependencies
package fpw_pkg;

    localparam logic [2:0] CMD_AT_NUMBER = 3'd0;
    localparam logic [2:0] CMD_AT_XY     = 3'd1;
    localparam logic [2:0] CMD_NEXT_X    = 3'd2;
    localparam logic [2:0] CMD_NEXT_Y    = 3'd3;
    localparam logic [2:0] CMD_NEXT_DIAG = 3'd4;

    localparam logic [1:0] MODE_RGB888 = 2'd0;
    localparam logic [1:0] MODE_RGB565 = 2'd1;
    localparam logic [1:0] MODE_RGB444 = 2'd2;

    localparam logic [1:0] REG_COLOR_MODE   = 2'd0;
    localparam logic [1:0] REG_BASE_ADDRESS = 2'd1;
    localparam logic [1:0] REG_LINE_WIDTH   = 2'd2;

    localparam logic [12:0] LINE_WIDTH_RESET = 13'd320;

    localparam logic [5:0] EN_RGB888   = 6'h3F;
    localparam logic [5:0] EN_RGB565   = 6'h0F;
    localparam logic [5:0] EN_444_EVEN = 6'h0B;
    localparam logic [5:0] EN_444_ODD  = 6'h0D;
    localparam logic [5:0] EN_NONE     = 6'h00;

    localparam logic [16:0] COLOR_FULL = 17'h10000;

    typedef struct packed {
        logic capture;
        logic finish;
    } fpw_cmd_t;

    // clamp a q1.16 channel to full and scale by m, truncating
    function automatic logic [7:0] scale_ch(input logic [16:0] c, input logic [7:0] m);
        logic [16:0] cc;
        logic [24:0] prod;
        cc   = (c > COLOR_FULL) ? COLOR_FULL : c;
        prod = 25'(cc) * 25'(m);
        return prod[23:16];
    endfunction

endpackage

[sv/framebuffer_pixel_writer_core.sv]
// framebuffer pixel writer: draw command in, one byte-addressed memory write out
// each item is registered in the capture stage, then in the output registers; a result not yet taken stalls the finish
// a new item is accepted only after the last one has finished: the capture stage (width-by-row multiply) is
// followed by the address add and color packing stage
// reset: color mode rgb888, base address 0, line width 320, cursor 0, even alignment
module framebuffer_pixel_writer_core
    import fpw_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [87:0] s_axis_tdata,  // x, y, red, green, blue
    input  logic [2:0]  s_axis_tuser,  // command
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // write_address, write_data, nibble_enable
);

    fpw_cmd_t    cmd;
    logic [31:0] write_address;
    logic [23:0] write_data;
    logic [5:0]  nibble_enable;

    fpw_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (s_axis_tvalid),
        .s_ready (s_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .cmd     (cmd)
    );

    fpw_datapath #(
        .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .cmd           (cmd),
        .in_command    (s_axis_tuser),
        .in_x          (s_axis_tdata[23:0]),
        .in_y          (s_axis_tdata[35:24]),
        .in_red        (s_axis_tdata[52:36]),
        .in_green      (s_axis_tdata[69:53]),
        .in_blue       (s_axis_tdata[86:70]),
        .write_address (write_address),
        .write_data    (write_data),
        .nibble_enable (nibble_enable)
    );

    assign m_axis_tdata = {2'b00, nibble_enable, write_data, write_address};

endmodule

[sv/fpw_ctrl.sv]
// controller of the pixel writer: capture and finish sequencing, output valid
// depends on fpw_pkg and assert_macros.svh
`include "assert_macros.svh"

module fpw_ctrl
    import fpw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    output fpw_cmd_t cmd
);

    typedef enum logic {
        S_IDLE,
        S_FIN
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd.capture    = (state_reg == S_IDLE) && s_valid;
        cmd.finish     = (state_reg == S_FIN) && (!out_valid_reg || m_ready);
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && m_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_valid)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (cmd.finish)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = out_valid_reg;

    `ASSERT_NEXT(a_capture_to_fin, cmd.capture, state_reg == S_FIN, "capture did not enter finish")
    `ASSERT_NEXT(a_finish_loads_out, cmd.finish, out_valid_reg, "finished result not presented")
    `ASSERT_SAME(a_no_overwrite, out_valid_reg && !m_ready, !cmd.finish, "pending result overwritten")

endmodule

[sv/fpw_datapath.sv]
// datapath of the pixel writer: config registers, cursor, address and color packing
// depends on fpw_pkg and assert_macros.svh
`include "assert_macros.svh"

module fpw_datapath
    import fpw_pkg::*;
#(
    parameter int MAX_LINE_WIDTH = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  fpw_cmd_t    cmd,
    input  logic [2:0]  in_command,
    input  logic [23:0] in_x,
    input  logic [11:0] in_y,
    input  logic [16:0] in_red,
    input  logic [16:0] in_green,
    input  logic [16:0] in_blue,
    output logic [31:0] write_address,
    output logic [23:0] write_data,
    output logic [5:0]  nibble_enable
);

    localparam logic [12:0] WIDTH_CAP =
        (MAX_LINE_WIDTH > 8191) ? 13'h1FFF : 13'(MAX_LINE_WIDTH);

    logic [1:0]  color_mode_reg;
    logic [31:0] base_address_reg;
    logic [12:0] line_width_reg;
    logic [31:0] cursor_reg, cursor_next;
    logic        odd_reg, odd_next;

    logic [2:0]  cmd_reg;
    logic [25:0] pix_reg;
    logic [15:0] incr_reg;
    logic        step_odd_reg;
    logic [16:0] red_reg, green_reg, blue_reg;

    logic [31:0] address_reg;
    logic [23:0] data_reg;
    logic [5:0]  enable_reg;

    logic [1:0]  mode;
    logic        is444;
    logic [12:0] w_capped, w_eff;
    logic [15:0] line_step;
    logic [1:0]  delta;
    logic        x_odd;
    logic [24:0] row_prod;
    logic [15:0] incr_now;
    logic        step_odd_now;

    logic        cmd_at, cmd_step, cmd_ok;
    logic [27:0] pix3;
    logic [27:0] offset;
    logic        odd_now;
    logic [7:0]  r8, g8, b8, r5, g6, b5, r4, g4, b4;
    logic [23:0] data_now;
    logic [5:0]  enable_now;

    always_comb
    begin
        case (color_mode_reg) inside
            MODE_RGB565, MODE_RGB444: mode = color_mode_reg;
            default:                  mode = MODE_RGB888;
        endcase
        is444    = (mode == MODE_RGB444);
        w_capped = (line_width_reg > WIDTH_CAP) ? WIDTH_CAP : line_width_reg;
        w_eff    = is444 ? {w_capped[12:1], 1'b0} : w_capped;
        unique case (mode)
            MODE_RGB565: line_step = 16'({w_eff, 1'b0});
            MODE_RGB444: line_step = 16'(w_eff[12:1]) + 16'({w_eff[12:1], 1'b0});
            default:     line_step = 16'(w_eff) + 16'({w_eff, 1'b0});
        endcase
        unique case (mode)
            MODE_RGB565: delta = 2'd2;
            MODE_RGB444: delta = odd_reg ? 2'd2 : 2'd1;
            default:     delta = 2'd3;
        endcase
        x_odd    = is444 && !odd_reg;
        row_prod = 25'(w_eff) * 25'(in_y);
        case (in_command)
            CMD_NEXT_X:
            begin
                incr_now     = 16'(delta);
                step_odd_now = x_odd;
            end
            CMD_NEXT_Y:
            begin
                incr_now     = line_step;
                step_odd_now = odd_reg;
            end
            CMD_NEXT_DIAG:
            begin
                incr_now     = line_step + 16'(delta);
                step_odd_now = x_odd;
            end
            default:
            begin
                incr_now     = 16'd0;
                step_odd_now = odd_reg;
            end
        endcase
    end

    // item capture, no reset needed
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg      <= in_command;
            pix_reg      <= (in_command == CMD_AT_XY) ? 26'(in_x) + 26'(row_prod) : 26'(in_x);
            incr_reg     <= incr_now;
            step_odd_reg <= step_odd_now;
            red_reg      <= in_red;
            green_reg    <= in_green;
            blue_reg     <= in_blue;
        end
    end

    always_comb
    begin
        cmd_at   = 1'b0;
        cmd_step = 1'b0;
        case (cmd_reg) inside
            CMD_AT_NUMBER, CMD_AT_XY:              cmd_at   = 1'b1;
            CMD_NEXT_X, CMD_NEXT_Y, CMD_NEXT_DIAG: cmd_step = 1'b1;
            default:                               cmd_at   = 1'b0;
        endcase
        cmd_ok = cmd_at || cmd_step;
        pix3   = 28'(pix_reg) + 28'({pix_reg, 1'b0});
        unique case (mode)
            MODE_RGB565: offset = 28'({pix_reg, 1'b0});
            MODE_RGB444: offset = pix3 >> 1;
            default:     offset = pix3;
        endcase
        cursor_next = cursor_reg;
        if (cmd_at)
        begin
            cursor_next = base_address_reg + 32'(offset);
        end
        else if (cmd_step)
        begin
            cursor_next = cursor_reg + 32'(incr_reg);
        end
        odd_now  = cmd_at ? pix_reg[0] : step_odd_reg;
        odd_next = (cmd_ok && is444) ? odd_now : odd_reg;

        r8 = scale_ch(red_reg, 8'd255);
        g8 = scale_ch(green_reg, 8'd255);
        b8 = scale_ch(blue_reg, 8'd255);
        r5 = scale_ch(red_reg, 8'd31);
        g6 = scale_ch(green_reg, 8'd63);
        b5 = scale_ch(blue_reg, 8'd31);
        r4 = scale_ch(red_reg, 8'd15);
        g4 = scale_ch(green_reg, 8'd15);
        b4 = scale_ch(blue_reg, 8'd15);
        unique case (mode)
            MODE_RGB565:
            begin
                data_now   = {8'h00, r5[4:0], g6[5:0], b5[4:0]};
                enable_now = EN_RGB565;
            end
            MODE_RGB444:
            begin
                if (odd_now)
                begin
                    data_now   = {8'h00, g4[3:0], b4[3:0], 4'h0, r4[3:0]};
                    enable_now = EN_444_ODD;
                end
                else
                begin
                    data_now   = {8'h00, b4[3:0], 4'h0, r4[3:0], g4[3:0]};
                    enable_now = EN_444_EVEN;
                end
            end
            default:
            begin
                data_now   = {b8, g8, r8};
                enable_now = EN_RGB888;
            end
        endcase
        if (!cmd_ok)
        begin
            data_now   = 24'h000000;
            enable_now = EN_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg   <= MODE_RGB888;
            base_address_reg <= 32'h0000_0000;
            line_width_reg   <= LINE_WIDTH_RESET;
            cursor_reg       <= 32'h0000_0000;
            odd_reg          <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                cursor_reg <= cursor_next;
                odd_reg    <= odd_next;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_COLOR_MODE:   color_mode_reg <= cfg_data[1:0];
                    REG_BASE_ADDRESS:
                    begin
                        base_address_reg <= cfg_data;
                        cursor_reg       <= cfg_data;
                    end
                    REG_LINE_WIDTH:   line_width_reg <= cfg_data[12:0];
                    default:          color_mode_reg <= color_mode_reg;
                endcase
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            address_reg <= cursor_next;
            data_reg    <= data_now;
            enable_reg  <= enable_now;
        end
    end

    assign write_address = address_reg;
    assign write_data    = data_reg;
    assign nibble_enable = enable_reg;

    `ASSERT_NEXT(a_base_sets_cursor, cfg_we && cfg_index == REG_BASE_ADDRESS, cursor_reg == $past(cfg_data), "cursor not set by base write")
    `ASSERT_NEXT(a_bad_cmd_keeps, cmd.finish && !cmd_ok && !cfg_we, cursor_reg == $past(cursor_reg) && odd_reg == $past(odd_reg), "unknown command changed state")

endmodule
